### sv/mcpi_pkg.sv
// ----------------------------------------------------------------------------
// mcpi_pkg
// Shared types and constants of the motor current PI controller: register
// map, mode codes, sequencer states and the command of the multiply-add unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpi_pkg;

	// Configuration port geometry.
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_KP         = 3'd0;
	localparam logic [2:0] REG_KI         = 3'd1;
	localparam logic [2:0] REG_PWM_PERIOD = 3'd2;
	localparam logic [2:0] REG_ADC_GAIN   = 3'd3;
	localparam logic [2:0] REG_ADC_OFFSET = 3'd4;
	localparam logic [2:0] REG_TEST_AMP   = 3'd5;

	// Register reset values.
	localparam logic [16:0] RST_PWM_PERIOD = 17'd4000;
	localparam logic [15:0] RST_ADC_GAIN   = 16'd33889;
	localparam logic [25:0] RST_ADC_OFFSET = 26'd30257971;
	localparam logic [14:0] RST_TEST_AMP   = 15'd200;

	// Mode codes; the undefined codes behave as idle.
	localparam logic [2:0] OP_IDLE   = 3'd0;
	localparam logic [2:0] OP_DIRECT = 3'd1;
	localparam logic [2:0] OP_TEST   = 3'd2;
	localparam logic [2:0] OP_HOLD   = 3'd3;
	localparam logic [2:0] OP_TRACK  = 3'd4;

	// Datapath widths of the shared multiply-add unit.
	localparam int unsigned MUL_A_W = 33;
	localparam int unsigned MUL_B_W = 17;
	localparam int unsigned ACC_W   = 51;

	// Duty limits and the reciprocal of 100 in Q0.30, split in two halves.
	localparam logic [6:0]  PCT_FULL    = 7'd100;
	localparam logic [16:0] PERIOD_MAX  = 17'd65536;
	localparam logic [11:0] MEAS_MAX    = 12'd4095;
	localparam int unsigned RECIP_SHIFT = 30;
	localparam int unsigned RECIP_SPLIT = 12;
	localparam logic [11:0] RECIP_HI    = 12'hA3D;
	localparam logic [11:0] RECIP_LO    = 12'h70B;

	// Configuration register contents.
	typedef struct packed {
		logic [15:0] kp;
		logic [15:0] ki;
		logic [16:0] pwm_period;
		logic [15:0] adc_gain;
		logic [25:0] adc_offset;
		logic [14:0] test_amplitude;
	} cfg_t;

	// Addend choice of the multiply-add unit.
	typedef enum logic [1:0] {
		ADD_ZERO    = 2'd0,
		ADD_OFFSET  = 2'd1,
		ADD_ACC     = 2'd2,
		ADD_ACC_SHL = 2'd3
	} add_sel_t;

	// One command to the multiply-add unit.
	typedef struct packed {
		logic               en;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
		add_sel_t           add_sel;
	} mac_cmd_t;

	// Sequencer states.
	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_SCALE  = 10'b0000000010,
		ST_MEAS   = 10'b0000000100,
		ST_INTEG  = 10'b0000001000,
		ST_KI     = 10'b0000010000,
		ST_MAG    = 10'b0000100000,
		ST_PER    = 10'b0001000000,
		ST_DHI    = 10'b0010000000,
		ST_DLO    = 10'b0100000000,
		ST_FINISH = 10'b1000000000
	} state_t;

endpackage

`default_nettype wire

### sv/mcpi_regs.sv
// ----------------------------------------------------------------------------
// mcpi_regs
// Configuration register file behind an APB-style port; always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpi_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mcpi_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [mcpi_pkg::DATA_W-1:0]  pwdata,
	output logic      [mcpi_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	output mcpi_pkg::cfg_t                    cfg
);

	mcpi_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	// Register writes complete in the access phase of a write transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp             <= '0;
			cfg_q.ki             <= '0;
			cfg_q.pwm_period     <= mcpi_pkg::RST_PWM_PERIOD;
			cfg_q.adc_gain       <= mcpi_pkg::RST_ADC_GAIN;
			cfg_q.adc_offset     <= mcpi_pkg::RST_ADC_OFFSET;
			cfg_q.test_amplitude <= mcpi_pkg::RST_TEST_AMP;
		end else if (wr_en) begin
			case (reg_idx)
				mcpi_pkg::REG_KP:         cfg_q.kp             <= pwdata[15:0];
				mcpi_pkg::REG_KI:         cfg_q.ki             <= pwdata[15:0];
				mcpi_pkg::REG_PWM_PERIOD: cfg_q.pwm_period     <= pwdata[16:0];
				mcpi_pkg::REG_ADC_GAIN:   cfg_q.adc_gain       <= pwdata[15:0];
				mcpi_pkg::REG_ADC_OFFSET: cfg_q.adc_offset     <= pwdata[25:0];
				mcpi_pkg::REG_TEST_AMP:   cfg_q.test_amplitude <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	// Read data mux; unmapped addresses read as zero.
	always_comb begin
		case (reg_idx)
			mcpi_pkg::REG_KP:         prdata = {16'b0, cfg_q.kp};
			mcpi_pkg::REG_KI:         prdata = {16'b0, cfg_q.ki};
			mcpi_pkg::REG_PWM_PERIOD: prdata = {15'b0, cfg_q.pwm_period};
			mcpi_pkg::REG_ADC_GAIN:   prdata = {16'b0, cfg_q.adc_gain};
			mcpi_pkg::REG_ADC_OFFSET: prdata = {6'b0, cfg_q.adc_offset};
			mcpi_pkg::REG_TEST_AMP:   prdata = {17'b0, cfg_q.test_amplitude};
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### sv/mcpi_mac.sv
// ----------------------------------------------------------------------------
// mcpi_mac
// Shared multiply-add unit: signed 33 by unsigned 17 bit product plus a
// selected addend, captured in one accumulator register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpi_mac (
	input  wire logic                             clk,
	input  wire mcpi_pkg::mac_cmd_t               cmd,
	input  wire logic [25:0]                      offset,
	output logic signed [mcpi_pkg::ACC_W-1:0]     acc
);

	localparam int unsigned ACC_W = mcpi_pkg::ACC_W;

	logic signed [ACC_W-1:0] product;
	logic signed [ACC_W-1:0] addend;
	logic signed [ACC_W-1:0] acc_q;

	assign acc = acc_q;

	// The B operand is unsigned, so it gets a zero sign bit.
	assign product = $signed(cmd.a) * $signed({1'b0, cmd.b});

	// Addend selection.
	always_comb begin
		case (cmd.add_sel)
			mcpi_pkg::ADD_ZERO:    addend = '0;
			mcpi_pkg::ADD_OFFSET:  addend = $signed({{(ACC_W-26){1'b0}}, offset});
			mcpi_pkg::ADD_ACC:     addend = acc_q;
			mcpi_pkg::ADD_ACC_SHL: addend = $signed({acc_q[ACC_W-1-mcpi_pkg::RECIP_SPLIT:0],
				{mcpi_pkg::RECIP_SPLIT{1'b0}}});
			default:               addend = '0;
		endcase
	end

	// Accumulator.
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			acc_q <= product + addend;
		end
	end

endmodule

`default_nettype wire

### sv/motor_current_pi_controller.sv
// ----------------------------------------------------------------------------
// motor_current_pi_controller
// Current-loop PI controller with PWM duty output, direct PWM and test modes.
// ----------------------------------------------------------------------------
// One transaction per control tick. A controlling mode (current test, hold,
// track) is run by a small sequencer that steps the tick through one shared
// multiply-add unit for the sample scaling, both gain products, the period
// scaling and the two halves of the division by 100, one step per cycle. A
// new tick is not accepted while an earlier one is in work. Idle and direct
// PWM ticks go straight to the last step, which loads their result. in_stall
// stays high while a tick is in work. The result sits in an output register,
// so a new tick may start while it waits. A finished tick that finds that
// register full and stalled waits in its last step for as long as the stall
// lasts. The error integral saturates at the signed 32-bit limits and is
// cleared only by reset. Registers may be written only while no tick is in
// work.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_current_pi_controller #(
	parameter int TEST_LENGTH = 100,
	parameter int ADC_BITS    = 10
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// Configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mcpi_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [mcpi_pkg::DATA_W-1:0]  pwdata,
	output logic      [mcpi_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	// Input channel
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [2:0]                   op,
	input  wire logic [9:0]                   adc_sample,
	input  wire logic signed [15:0]           desired_current,
	input  wire logic                         pwm_dir,
	input  wire logic [15:0]                  pwm_duty,
	// Output channel
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [16:0]                       duty,
	output logic                              direction,
	output logic                              record_valid,
	output logic signed [15:0]                reference,
	output logic [11:0]                       measured,
	output logic                              record_last
);

	localparam int unsigned ACC_W = mcpi_pkg::ACC_W;

	// Square-wave quarter marks and the last test tick.
	localparam logic [6:0] MARK_Q1   = 7'(TEST_LENGTH / 4);
	localparam logic [6:0] MARK_Q2   = 7'(TEST_LENGTH / 2);
	localparam logic [6:0] MARK_Q3   = 7'((3 * TEST_LENGTH) / 4);
	localparam logic [6:0] TEST_LAST = 7'(TEST_LENGTH);

	// Only the low converter bits of the sample are used.
	localparam int         SAMPLE_BITS = (ADC_BITS < 10) ? ADC_BITS : 10;
	localparam logic [9:0] SAMPLE_MASK = 10'((1 << SAMPLE_BITS) - 1);

	mcpi_pkg::cfg_t      cfg;
	mcpi_pkg::mac_cmd_t  mac_cmd;
	logic signed [ACC_W-1:0] acc;

	mcpi_pkg::state_t    state_q;
	logic [2:0]          op_q;
	logic                ctrl_q;
	logic [9:0]          sample_q;
	logic signed [15:0]  ref_q;
	logic [15:0]         pwm_duty_q;
	logic                last_q;
	logic [11:0]         meas_q;
	logic signed [17:0]  err_q;
	logic signed [31:0]  integ_q;
	logic [6:0]          mag_q;
	logic [22:0]         x_q;
	logic                drive_dir_q;
	logic [6:0]          test_cnt_q;

	logic                out_valid_q;
	logic [16:0]         duty_q;
	logic                direction_q;
	logic                record_valid_q;
	logic signed [15:0]  reference_q;
	logic [11:0]         measured_q;
	logic                record_last_q;

	logic                in_fire;
	logic                out_free;
	logic                op_ctrl;
	logic                sq_neg;
	logic signed [15:0]  ref_next;
	logic [34:0]         acc_hi;
	logic [11:0]         meas_sat;
	logic signed [17:0]  err_next;
	logic signed [32:0]  integ_sum;
	logic signed [31:0]  integ_sat;
	logic signed [ACC_W-1:0] acc_abs;
	logic [6:0]          mag_next;
	logic [16:0]         per_clamped;

	mcpi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mcpi_mac u_mac (
		.clk    (clk),
		.cmd    (mac_cmd),
		.offset (cfg.adc_offset),
		.acc    (acc)
	);

	// Handshakes.
	assign in_stall = (state_q != mcpi_pkg::ST_IDLE);
	assign in_fire  = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	// Mode decode and the reference of the arriving tick.
	always_comb begin
		op_ctrl = (op == mcpi_pkg::OP_TEST) || (op == mcpi_pkg::OP_HOLD) ||
			(op == mcpi_pkg::OP_TRACK);
		sq_neg  = (test_cnt_q >= MARK_Q1) ^ (test_cnt_q >= MARK_Q2) ^
			(test_cnt_q >= MARK_Q3);
		if (op == mcpi_pkg::OP_TEST) begin
			ref_next = sq_neg ? -$signed({1'b0, cfg.test_amplitude})
				: $signed({1'b0, cfg.test_amplitude});
		end else if (op_ctrl) begin
			ref_next = desired_current;
		end else begin
			ref_next = '0;
		end
	end

	// Measured current, error, integral and effort magnitude.
	always_comb begin
		acc_hi    = acc[ACC_W-1:16];
		meas_sat  = (acc_hi > {23'b0, mcpi_pkg::MEAS_MAX}) ? mcpi_pkg::MEAS_MAX
			: acc_hi[11:0];
		err_next  = $signed({{2{ref_q[15]}}, ref_q}) - $signed({6'b0, meas_sat});
		integ_sum = $signed({integ_q[31], integ_q}) + $signed({{15{err_q[17]}}, err_q});
		if (integ_sum[32] != integ_sum[31]) begin
			integ_sat = integ_sum[32] ? $signed({1'b1, 31'b0}) : $signed({1'b0, {31{1'b1}}});
		end else begin
			integ_sat = integ_sum[31:0];
		end
		acc_abs  = acc[ACC_W-1] ? -acc : acc;
		mag_next = (acc_abs > $signed({{(ACC_W-7){1'b0}}, mcpi_pkg::PCT_FULL}))
			? mcpi_pkg::PCT_FULL : acc_abs[6:0];
		per_clamped = (cfg.pwm_period > mcpi_pkg::PERIOD_MAX) ? mcpi_pkg::PERIOD_MAX
			: cfg.pwm_period;
	end

	// Operands of the shared unit for each sequencer step.
	always_comb begin
		mac_cmd.en      = 1'b0;
		mac_cmd.a       = '0;
		mac_cmd.b       = '0;
		mac_cmd.add_sel = mcpi_pkg::ADD_ZERO;
		case (state_q)
			mcpi_pkg::ST_SCALE: begin
				mac_cmd.en      = 1'b1;
				mac_cmd.a       = {23'b0, sample_q & SAMPLE_MASK};
				mac_cmd.b       = {1'b0, cfg.adc_gain};
				mac_cmd.add_sel = mcpi_pkg::ADD_OFFSET;
			end
			mcpi_pkg::ST_INTEG: begin
				mac_cmd.en      = 1'b1;
				mac_cmd.a       = {{15{err_q[17]}}, err_q};
				mac_cmd.b       = {1'b0, cfg.kp};
			end
			mcpi_pkg::ST_KI: begin
				mac_cmd.en      = 1'b1;
				mac_cmd.a       = {integ_q[31], integ_q};
				mac_cmd.b       = {1'b0, cfg.ki};
				mac_cmd.add_sel = mcpi_pkg::ADD_ACC;
			end
			mcpi_pkg::ST_PER: begin
				mac_cmd.en      = 1'b1;
				mac_cmd.a       = {16'b0, per_clamped};
				mac_cmd.b       = {10'b0, mag_q};
			end
			mcpi_pkg::ST_DHI: begin
				mac_cmd.en      = 1'b1;
				mac_cmd.a       = {10'b0, acc[22:0]};
				mac_cmd.b       = {5'b0, mcpi_pkg::RECIP_HI};
			end
			mcpi_pkg::ST_DLO: begin
				mac_cmd.en      = 1'b1;
				mac_cmd.a       = {10'b0, x_q};
				mac_cmd.b       = {5'b0, mcpi_pkg::RECIP_LO};
				mac_cmd.add_sel = mcpi_pkg::ADD_ACC_SHL;
			end
			default: ;
		endcase
	end

	// Sequencer and the state kept across ticks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mcpi_pkg::ST_IDLE;
			integ_q     <= '0;
			test_cnt_q  <= '0;
			drive_dir_q <= 1'b0;
		end else begin
			case (state_q)
				mcpi_pkg::ST_IDLE: begin
					if (in_fire) begin
						state_q <= op_ctrl ? mcpi_pkg::ST_SCALE : mcpi_pkg::ST_FINISH;
						if (op == mcpi_pkg::OP_DIRECT) begin
							drive_dir_q <= pwm_dir;
						end
						if (op == mcpi_pkg::OP_TEST) begin
							test_cnt_q <= (test_cnt_q >= TEST_LAST) ? 7'd0 : test_cnt_q + 7'd1;
						end
					end
				end
				mcpi_pkg::ST_SCALE: state_q <= mcpi_pkg::ST_MEAS;
				mcpi_pkg::ST_MEAS:  state_q <= mcpi_pkg::ST_INTEG;
				mcpi_pkg::ST_INTEG: begin
					integ_q <= integ_sat;
					state_q <= mcpi_pkg::ST_KI;
				end
				mcpi_pkg::ST_KI:    state_q <= mcpi_pkg::ST_MAG;
				mcpi_pkg::ST_MAG: begin
					drive_dir_q <= acc[ACC_W-1];
					state_q     <= mcpi_pkg::ST_PER;
				end
				mcpi_pkg::ST_PER:   state_q <= mcpi_pkg::ST_DHI;
				mcpi_pkg::ST_DHI:   state_q <= mcpi_pkg::ST_DLO;
				mcpi_pkg::ST_DLO:   state_q <= mcpi_pkg::ST_FINISH;
				mcpi_pkg::ST_FINISH: begin
					if (out_free) begin
						state_q <= mcpi_pkg::ST_IDLE;
					end
				end
				default: state_q <= mcpi_pkg::ST_IDLE;
			endcase
		end
	end

	// Per-tick working registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q       <= op;
			ctrl_q     <= op_ctrl;
			sample_q   <= adc_sample;
			ref_q      <= ref_next;
			pwm_duty_q <= pwm_duty;
			last_q     <= (op == mcpi_pkg::OP_TEST) && (test_cnt_q >= TEST_LAST);
			meas_q     <= '0;
		end
		if (state_q == mcpi_pkg::ST_MEAS) begin
			meas_q <= meas_sat;
			err_q  <= err_next;
		end
		if (state_q == mcpi_pkg::ST_MAG) begin
			mag_q <= mag_next;
		end
		if (state_q == mcpi_pkg::ST_DHI) begin
			x_q <= acc[22:0];
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == mcpi_pkg::ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, loaded when the tick finishes.
	always_ff @(posedge clk) begin
		if ((state_q == mcpi_pkg::ST_FINISH) && out_free) begin
			if (ctrl_q) begin
				duty_q <= acc[mcpi_pkg::RECIP_SHIFT+16:mcpi_pkg::RECIP_SHIFT];
			end else if (op_q == mcpi_pkg::OP_DIRECT) begin
				duty_q <= {1'b0, pwm_duty_q};
			end else begin
				duty_q <= '0;
			end
			direction_q    <= drive_dir_q;
			record_valid_q <= (op_q == mcpi_pkg::OP_TEST);
			reference_q    <= ref_q;
			measured_q     <= meas_q;
			record_last_q  <= last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign duty         = duty_q;
	assign direction    = direction_q;
	assign record_valid = record_valid_q;
	assign reference    = reference_q;
	assign measured     = measured_q;
	assign record_last  = record_last_q;

endmodule

`default_nettype wire
